// ===== sv/i2crm_pkg.sv =====
// Package for the register-access two-wire bus master.
// Holds the item and result types, phase codes, mode codes and constants.
// No dependencies.
package i2crm_pkg;

    // Acknowledge wait limit in high ticks
    localparam logic [7:0] ACK_TIMEOUT = 8'd250;
    localparam logic [6:0] ADDR_RESET  = 7'd42;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Command codes carried with each item
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_FALL = 4'd1,
        PH_RS_LOW  = 4'd2,
        PH_RS_HIGH = 4'd3,
        PH_TX_LO   = 4'd4,
        PH_TX_HI   = 4'd5,
        PH_AK_LO   = 4'd6,
        PH_AK_HI   = 4'd7,
        PH_RX_LO   = 4'd8,
        PH_RX_HI   = 4'd9,
        PH_MA_LO   = 4'd10,
        PH_MA_HI   = 4'd11,
        PH_SP_A    = 4'd12,
        PH_SP_B    = 4'd13,
        PH_SP_C    = 4'd14
    } t_phase;

    // Byte sequence positions
    localparam logic [2:0] STEP_ADDR  = 3'd0;
    localparam logic [2:0] STEP_PTR   = 3'd1;
    localparam logic [2:0] STEP_MSB   = 3'd2;
    localparam logic [2:0] STEP_LSB   = 3'd3;
    localparam logic [2:0] STEP_RX2   = 3'd4;

    // One input item (one half-bit tick)
    typedef struct packed {
        t_mode       mode;
        logic [7:0]  reg_pointer;
        logic [15:0] write_word;
        logic        sda_sample;
    } t_item;

    // One result item
    typedef struct packed {
        logic        scl_level;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
        logic [15:0] read_word;
    } t_result;

endpackage

// ===== sv/i2crm_core.sv =====
// Bus sequencer of the register-access master: phase state and next-state logic.
// Consumes one tick item per step and produces its result combinationally.
// Depends on i2crm_pkg.
module i2crm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [6:0]        i_cfg_wr_data,
    input  logic              i_step,
    input  i2crm_pkg::t_item  i_item,
    output i2crm_pkg::t_result o_result
);
    import i2crm_pkg::*;

    // Sequencer state
    logic [6:0]  r_dev_addr;
    t_phase      r_phase,     n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [2:0]  r_byte_step, n_byte_step;
    logic [7:0]  r_shift,     n_shift;
    logic [15:0] r_read_hold, n_read_hold;
    logic [7:0]  r_ack_count, n_ack_count;
    logic        r_cmd_read,  n_cmd_read;
    logic [7:0]  r_cmd_ptr,   n_cmd_ptr;
    logic [15:0] r_cmd_word,  n_cmd_word;
    logic        r_error,     n_error;

    logic        scl_o, sda_o, busy_o, done_o;
    logic        do_after;
    logic [3:0]  bit_inc;

    // Byte to send at a given step of the sequence
    function automatic logic [7:0] f_load_byte(
        input logic [2:0]  step,
        input logic        rd,
        input logic [6:0]  addr,
        input logic [7:0]  ptr,
        input logic [15:0] word
    );
        logic [7:0] b;
        if (step == STEP_ADDR) begin
            b = {addr, 1'b0};
        end else if (step == STEP_PTR) begin
            b = ptr;
        end else if (rd) begin
            b = {addr, 1'b1};
        end else if (step == STEP_MSB) begin
            b = word[15:8];
        end else begin
            b = word[7:0];
        end
        return b;
    endfunction

    assign bit_inc = r_bit_count + 4'd1;

    // Next state and line levels for this tick
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_byte_step = r_byte_step;
        n_shift     = r_shift;
        n_read_hold = r_read_hold;
        n_ack_count = r_ack_count;
        n_cmd_read  = r_cmd_read;
        n_cmd_ptr   = r_cmd_ptr;
        n_cmd_word  = r_cmd_word;
        n_error     = r_error;
        scl_o       = 1'b1;
        sda_o       = 1'b1;
        busy_o      = 1'b1;
        done_o      = 1'b0;
        do_after    = 1'b0;

        case (r_phase)
            PH_ST_FALL: begin
                sda_o       = 1'b0;
                n_shift     = f_load_byte(r_byte_step, r_cmd_read, r_dev_addr,
                                          r_cmd_ptr, r_cmd_word);
                n_bit_count = 4'd0;
                n_phase     = PH_TX_LO;
            end
            PH_RS_LOW: begin
                scl_o   = 1'b0;
                n_phase = PH_RS_HIGH;
            end
            PH_RS_HIGH: begin
                n_phase = PH_ST_FALL;
            end
            PH_TX_LO: begin
                scl_o   = 1'b0;
                sda_o   = r_shift[7];
                n_phase = PH_TX_HI;
            end
            PH_TX_HI: begin
                sda_o       = r_shift[7];
                n_shift     = {r_shift[6:0], 1'b0};
                n_bit_count = bit_inc;
                n_phase     = (bit_inc >= BITS_PER_BYTE) ? PH_AK_LO : PH_TX_LO;
            end
            PH_AK_LO: begin
                scl_o       = 1'b0;
                n_ack_count = 8'd0;
                n_phase     = PH_AK_HI;
            end
            PH_AK_HI: begin
                if (!i_item.sda_sample) begin
                    do_after = 1'b1;
                end else if (r_ack_count >= ACK_TIMEOUT) begin
                    // only address and data acks of a write are checked
                    if (!r_cmd_read && r_byte_step != STEP_PTR) begin
                        n_error = 1'b1;
                        n_phase = PH_SP_A;
                    end else begin
                        do_after = 1'b1;
                    end
                end else begin
                    n_ack_count = r_ack_count + 8'd1;
                end
            end
            PH_RX_LO: begin
                scl_o   = 1'b0;
                n_phase = PH_RX_HI;
            end
            PH_RX_HI: begin
                n_shift     = {r_shift[6:0], i_item.sda_sample};
                n_bit_count = bit_inc;
                n_phase     = (bit_inc >= BITS_PER_BYTE) ? PH_MA_LO : PH_RX_LO;
            end
            PH_MA_LO: begin
                scl_o   = 1'b0;
                sda_o   = (r_byte_step != STEP_LSB);
                n_phase = PH_MA_HI;
            end
            PH_MA_HI: begin
                sda_o = (r_byte_step != STEP_LSB);
                if (r_byte_step == STEP_LSB) begin
                    // first byte read: store MSB, ACK, read the next
                    n_read_hold = {r_shift, r_read_hold[7:0]};
                    n_byte_step = STEP_RX2;
                    n_bit_count = 4'd0;
                    n_shift     = 8'd0;
                    n_phase     = PH_RX_LO;
                end else begin
                    n_read_hold = {r_read_hold[15:8], r_shift};
                    n_phase     = PH_SP_A;
                end
            end
            PH_SP_A: begin
                scl_o   = 1'b0;
                sda_o   = 1'b0;
                n_phase = PH_SP_B;
            end
            PH_SP_B: begin
                sda_o   = 1'b0;
                n_phase = PH_SP_C;
            end
            PH_SP_C: begin
                done_o  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                // idle: take a new command
                n_phase = PH_IDLE;
                if (i_item.mode == MODE_WRITE || i_item.mode == MODE_READ) begin
                    n_cmd_read  = (i_item.mode == MODE_READ);
                    n_cmd_ptr   = i_item.reg_pointer;
                    n_cmd_word  = i_item.write_word;
                    n_error     = 1'b0;
                    n_byte_step = STEP_ADDR;
                    n_bit_count = 4'd0;
                    n_ack_count = 8'd0;
                    n_phase     = PH_ST_FALL;
                end else begin
                    busy_o = 1'b0;
                end
            end
        endcase

        // Continue after an acknowledged (or tolerated) byte
        if (do_after) begin
            if (r_cmd_read) begin
                if (r_byte_step == STEP_ADDR) begin
                    n_byte_step = STEP_PTR;
                    n_shift     = f_load_byte(STEP_PTR, r_cmd_read, r_dev_addr,
                                              r_cmd_ptr, r_cmd_word);
                    n_bit_count = 4'd0;
                    n_phase     = PH_TX_LO;
                end else if (r_byte_step == STEP_PTR) begin
                    n_byte_step = STEP_MSB;
                    n_phase     = PH_RS_LOW;
                end else begin
                    n_byte_step = STEP_LSB;
                    n_bit_count = 4'd0;
                    n_shift     = 8'd0;
                    n_phase     = PH_RX_LO;
                end
            end else if (r_byte_step >= STEP_LSB) begin
                n_phase = PH_SP_A;
            end else begin
                n_byte_step = r_byte_step + 3'd1;
                n_shift     = f_load_byte(r_byte_step + 3'd1, r_cmd_read, r_dev_addr,
                                          r_cmd_ptr, r_cmd_word);
                n_bit_count = 4'd0;
                n_phase     = PH_TX_LO;
            end
        end
    end

    // Result of this tick
    always_comb begin
        o_result.scl_level = scl_o;
        o_result.sda_drive = sda_o;
        o_result.busy_res  = busy_o;
        o_result.done_res  = done_o;
        o_result.ack_error = n_error;
        o_result.read_word = n_read_hold;
    end

    // Device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
        end
    end

    // State update, once per tick item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= 4'd0;
            r_byte_step <= STEP_ADDR;
            r_shift     <= 8'd0;
            r_read_hold <= 16'd0;
            r_ack_count <= 8'd0;
            r_cmd_read  <= 1'b0;
            r_cmd_ptr   <= 8'd0;
            r_cmd_word  <= 16'd0;
            r_error     <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_byte_step <= n_byte_step;
            r_shift     <= n_shift;
            r_read_hold <= n_read_hold;
            r_ack_count <= n_ack_count;
            r_cmd_read  <= n_cmd_read;
            r_cmd_ptr   <= n_cmd_ptr;
            r_cmd_word  <= n_cmd_word;
            r_error     <= n_error;
        end
    end

endmodule

// ===== sv/i2c_register_master.sv =====
// Top level of the register-access two-wire bus master.
// Input item register, sequencer core and result register.
// Depends on i2crm_pkg and i2crm_core.
//
// Usage:
//   Each item on the slave stream is one half-bit tick of the bus. tuser
//   carries the command (tick, register write, register read); tdata the
//   register pointer, the write word and the sampled SDA level. For every
//   item exactly one result item leaves on the master stream with the SCL
//   and SDA levels to drive for that tick, busy/done/error flags and the
//   last word read. The target address is set through the write-enable
//   configuration port; the user must do so only while the bus is idle,
//   which the block itself does not enforce. An accepted item is held in
//   the input register and stepped through the sequencer into the result
//   register when that register is free or being emptied.
//   Throughput: one item per cycle while the receiver takes results; the
//   sequencer update is combinational logic between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; the slave side then deasserts tready until the result
//   is taken.
//   Reset (synchronous, active low) returns the bus to idle, the address
//   to 42 and empties both registers.
module i2c_register_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] reg_pointer, [23:8] write_word, [24] sda_sample, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_drive, [2] busy_res, [3] done_res,
    // [4] ack_error, [20:5] read_word, [23:21] zero
    output logic [23:0] m_axis_tdata
);
    import i2crm_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result core_res;
    logic    step;
    logic    in_take;

    // A held item advances when the result register is free or being emptied
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.mode        <= t_mode'(s_axis_tuser);
            r_in_item.reg_pointer <= s_axis_tdata[7:0];
            r_in_item.write_word  <= s_axis_tdata[23:8];
            r_in_item.sda_sample  <= s_axis_tdata[24];
        end
    end

    i2crm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_item        (r_in_item),
        .o_result      (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_res.read_word, r_out_res.ack_error,
                            r_out_res.done_res, r_out_res.busy_res,
                            r_out_res.sda_drive, r_out_res.scl_level};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for i2c_register_master: drives half-bit ticks with a
// modeled slave on SDA and checks every result against a cycle-exact bus model.
// Depends on i2crm_pkg and the RTL of i2c_register_master only.
module testbench;
    import i2crm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 200;
    localparam int NUM_ROWS     = 12;

    typedef enum logic [1:0] {
        ROW_TICK = 2'd0,
        ROW_TXN  = 2'd1,
        ROW_CFG  = 2'd2
    } t_row_kind;

    // Directed row: a single tick, a whole transaction or an address change.
    // ack_dly byte k is the number of high samples before the slave pulls SDA
    // low on ack k (0 address, 1 pointer, 2 MSB or read address, 3 LSB);
    // 8'hFF never acks.
    typedef struct packed {
        t_row_kind   kind;
        t_mode       mode;
        logic [7:0]  ptr;
        logic [15:0] word;
        logic [31:0] ack_dly;
        logic [15:0] slave_word;
        logic        chk_err;
        logic        exp_err;
        logic        chk_word;
        logic [15:0] exp_word;
    } t_row;

    // Known end state of one transaction, checked on its done tick
    typedef struct packed {
        logic        chk_err;
        logic        err;
        logic        chk_word;
        logic [15:0] word;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [7:0] reg_pointer, [23:8] write_word, [24] sda_sample
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [0] scl, [1] sda, [2] busy, [3] done, [4] ack_error,
                                 // [20:5] read_word

    i2c_register_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Bus sequencer model state
    t_phase      bus_ph;
    logic [3:0]  bit_cnt;
    logic [2:0]  byte_idx;
    logic [7:0]  shreg;
    logic [15:0] rd_hold;
    logic [7:0]  ack_cnt;
    logic        cmd_rd;
    logic [7:0]  cmd_ptr;
    logic [15:0] cmd_word;
    logic        err_flag;
    logic [6:0]  dev_addr;

    t_result  bus_levels_q [$];
    t_outcome txn_end_q [$];
    t_row     dir_rows [NUM_ROWS];

    int n_items   = 0;
    int n_results = 0;
    int n_mism    = 0;
    int cycles    = 0;
    bit in_burst  = 1'b0;
    bit hold_req  = 1'b0;

    // Byte to shift out for the current position in the sequence
    function automatic void load_tx_byte();
        if (byte_idx == STEP_ADDR) shreg = {dev_addr, 1'b0};
        else if (byte_idx == STEP_PTR) shreg = cmd_ptr;
        else if (cmd_rd) shreg = {dev_addr, 1'b1};
        else if (byte_idx == STEP_MSB) shreg = cmd_word[15:8];
        else shreg = cmd_word[7:0];
        bit_cnt = 4'd0;
        bus_ph  = PH_TX_LO;
    endfunction

    // Where the sequence goes once a sent byte's ack wait is over
    function automatic void next_after_ack();
        if (cmd_rd) begin
            if (byte_idx == STEP_ADDR) begin
                byte_idx = STEP_PTR;
                load_tx_byte();
            end else if (byte_idx == STEP_PTR) begin
                byte_idx = STEP_MSB;
                bus_ph   = PH_RS_LOW;
            end else begin
                byte_idx = STEP_LSB;
                bit_cnt  = 4'd0;
                shreg    = 8'd0;
                bus_ph   = PH_RX_LO;
            end
        end else if (byte_idx >= STEP_LSB) begin
            bus_ph = PH_SP_A;
        end else begin
            byte_idx = byte_idx + 3'd1;
            load_tx_byte();
        end
    endfunction

    // One half-bit tick of the master: returns the levels and flags for it
    function automatic t_result bus_tick(input t_item it);
        t_result r;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_drive = 1'b1;
        r.busy_res  = 1'b1;
        case (bus_ph)
            PH_ST_FALL: begin
                r.sda_drive = 1'b0;
                load_tx_byte();
            end
            PH_RS_LOW: begin
                r.scl_level = 1'b0;
                bus_ph = PH_RS_HIGH;
            end
            PH_RS_HIGH: bus_ph = PH_ST_FALL;
            PH_TX_LO: begin
                r.scl_level = 1'b0;
                r.sda_drive = shreg[7];
                bus_ph = PH_TX_HI;
            end
            PH_TX_HI: begin
                r.sda_drive = shreg[7];
                shreg   = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= BITS_PER_BYTE) bus_ph = PH_AK_LO;
                else bus_ph = PH_TX_LO;
            end
            PH_AK_LO: begin
                r.scl_level = 1'b0;
                ack_cnt = 8'd0;
                bus_ph  = PH_AK_HI;
            end
            PH_AK_HI: begin
                if (!it.sda_sample) begin
                    next_after_ack();
                end else if (ack_cnt >= ACK_TIMEOUT) begin
                    // only address, MSB and LSB acks of a write are checked
                    if (!cmd_rd && byte_idx != STEP_PTR) begin
                        err_flag = 1'b1;
                        bus_ph   = PH_SP_A;
                    end else begin
                        next_after_ack();
                    end
                end else begin
                    ack_cnt = ack_cnt + 8'd1;
                end
            end
            PH_RX_LO: begin
                r.scl_level = 1'b0;
                bus_ph = PH_RX_HI;
            end
            PH_RX_HI: begin
                shreg   = {shreg[6:0], it.sda_sample};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= BITS_PER_BYTE) bus_ph = PH_MA_LO;
                else bus_ph = PH_RX_LO;
            end
            PH_MA_LO: begin
                r.scl_level = 1'b0;
                r.sda_drive = (byte_idx != STEP_LSB);
                bus_ph = PH_MA_HI;
            end
            PH_MA_HI: begin
                // ACK after the MSB byte, NACK after the LSB byte
                r.sda_drive = (byte_idx != STEP_LSB);
                if (byte_idx == STEP_LSB) begin
                    rd_hold[15:8] = shreg;
                    byte_idx = STEP_RX2;
                    bit_cnt  = 4'd0;
                    shreg    = 8'd0;
                    bus_ph   = PH_RX_LO;
                end else begin
                    rd_hold[7:0] = shreg;
                    bus_ph = PH_SP_A;
                end
            end
            PH_SP_A: begin
                r.scl_level = 1'b0;
                r.sda_drive = 1'b0;
                bus_ph = PH_SP_B;
            end
            PH_SP_B: begin
                r.sda_drive = 1'b0;
                bus_ph = PH_SP_C;
            end
            PH_SP_C: begin
                r.done_res = 1'b1;
                bus_ph = PH_IDLE;
            end
            default: begin
                bus_ph = PH_IDLE;
                if (it.mode == MODE_WRITE || it.mode == MODE_READ) begin
                    cmd_rd   = (it.mode == MODE_READ);
                    cmd_ptr  = it.reg_pointer;
                    cmd_word = it.write_word;
                    err_flag = 1'b0;
                    byte_idx = STEP_ADDR;
                    bit_cnt  = 4'd0;
                    ack_cnt  = 8'd0;
                    bus_ph   = PH_ST_FALL;
                end else begin
                    r.busy_res = 1'b0;
                end
            end
        endcase
        r.ack_error = err_flag;
        r.read_word = rd_hold;
        return r;
    endfunction

    // Slave side of SDA for the coming tick; don't-care ticks get noise
    function automatic logic slave_sda(input logic [31:0] ack_dly,
                                       input logic [15:0] sword);
        case (bus_ph)
            PH_AK_HI: return (ack_cnt < ack_dly[byte_idx*8 +: 8]);
            PH_RX_HI: begin
                if (byte_idx == STEP_LSB) return sword[4'd15 - bit_cnt];
                return sword[4'd7 - bit_cnt];
            end
            default: return ($urandom_range(0, 1) != 0);
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input logic [15:0] want,
                                          input logic [15:0] got);
        n_mism++;
        if (n_mism <= 10)
            $display("mismatch on result %0d: %s expected %h got %h",
                     n_results, what, want, got);
    endfunction

    // Offer one item after a random gap and model it once accepted
    task automatic send_item(input t_mode m, input logic [7:0] ptr,
                             input logic [15:0] word, input logic s);
        t_item it;
        int    gap;
        int    r;
        r = $urandom_range(0, 99);
        if (in_burst || r < 70) gap = 0;
        else if (r < 94) gap = $urandom_range(1, 3);
        else gap = $urandom_range(6, 30);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.mode        = m;
        it.reg_pointer = ptr;
        it.write_word  = word;
        it.sda_sample  = s;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, s, word, ptr};
        s_axis_tuser  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
        bus_levels_q.push_back(bus_tick(it));
        n_items++;
    endtask

    // Command item, then ticks until the bus is idle again; a few commands
    // and reserved modes are thrown in while busy and must be ignored
    task automatic run_txn(input t_mode m, input logic [7:0] ptr, input logic [15:0] word,
                           input logic [31:0] ack_dly, input logic [15:0] sword,
                           input t_outcome oc);
        logic s;
        txn_end_q.push_back(oc);
        send_item(m, ptr, word, ($urandom_range(0, 1) != 0));
        while (bus_ph != PH_IDLE) begin
            s = slave_sda(ack_dly, sword);
            if ($urandom_range(0, 99) < 4)
                send_item(t_mode'($urandom_range(1, 3)), 8'($urandom), 16'($urandom), s);
            else
                send_item(MODE_TICK, 8'($urandom), 16'($urandom), s);
        end
    endtask

    // Address change only once every result is back
    task automatic set_address(input logic [6:0] v);
        s_axis_tvalid <= 1'b0;
        while (bus_levels_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dev_addr = v;
    endtask

    // Receiver: short and long stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int stall_left;
        int seg_left;
        int r;
        bit calm;
        stall_left = 0;
        seg_left   = 0;
        calm       = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(50, 300);
                calm = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 150;
            end else if (stall_left == 0 && !calm) begin
                r = $urandom_range(0, 99);
                if (r < 12) stall_left = $urandom_range(1, 3);
                else if (r < 14) stall_left = $urandom_range(8, 40);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result  want;
        t_result  got;
        t_outcome oc;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scl_level = m_axis_tdata[0];
            got.sda_drive = m_axis_tdata[1];
            got.busy_res  = m_axis_tdata[2];
            got.done_res  = m_axis_tdata[3];
            got.ack_error = m_axis_tdata[4];
            got.read_word = m_axis_tdata[20:5];
            if (bus_levels_q.size() == 0) begin
                flag_mismatch("unexpected result, tdata", 16'd0, m_axis_tdata[15:0]);
            end else begin
                want = bus_levels_q.pop_front();
                if (got.scl_level !== want.scl_level)
                    flag_mismatch("scl_level", 16'(want.scl_level), 16'(got.scl_level));
                if (got.sda_drive !== want.sda_drive)
                    flag_mismatch("sda_drive", 16'(want.sda_drive), 16'(got.sda_drive));
                if (got.busy_res !== want.busy_res)
                    flag_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                if (got.done_res !== want.done_res)
                    flag_mismatch("done_res", 16'(want.done_res), 16'(got.done_res));
                if (got.ack_error !== want.ack_error)
                    flag_mismatch("ack_error", 16'(want.ack_error), 16'(got.ack_error));
                if (got.read_word !== want.read_word)
                    flag_mismatch("read_word", want.read_word, got.read_word);
                if (want.done_res && txn_end_q.size() != 0) begin
                    oc = txn_end_q.pop_front();
                    if (oc.chk_err && got.ack_error !== oc.err)
                        flag_mismatch("ack_error at stop", 16'(oc.err), 16'(got.ack_error));
                    if (oc.chk_word && got.read_word !== oc.word)
                        flag_mismatch("word read at stop", oc.word, got.read_word);
                end
            end
            n_results++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        t_row        row;
        int          base_items;
        int          txn_no;
        int          r;
        logic [31:0] ack_dly;
        logic [6:0]  a;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 7'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        s_axis_tuser  <= MODE_TICK;

        bus_ph   = PH_IDLE;
        bit_cnt  = 4'd0;
        byte_idx = STEP_ADDR;
        shreg    = 8'd0;
        rd_hold  = 16'd0;
        ack_cnt  = 8'd0;
        cmd_rd   = 1'b0;
        cmd_ptr  = 8'd0;
        cmd_word = 16'd0;
        err_flag = 1'b0;
        dev_addr = ADDR_RESET;

        // kind, mode, ptr, word, ack delays, slave word, chk_err, err, chk_word, word
        dir_rows[0]  = '{ROW_TICK, MODE_TICK,  8'h00, 16'h0000, 32'h00000000, 16'h0000,
                         1'b0, 1'b0, 1'b0, 16'h0000};
        dir_rows[1]  = '{ROW_TICK, MODE_RSVD,  8'hFF, 16'hFFFF, 32'h00000000, 16'h0000,
                         1'b0, 1'b0, 1'b0, 16'h0000};
        dir_rows[2]  = '{ROW_TXN,  MODE_WRITE, 8'h00, 16'h0000, 32'h00000000, 16'h0000,
                         1'b1, 1'b0, 1'b0, 16'h0000};
        dir_rows[3]  = '{ROW_TXN,  MODE_READ,  8'hFF, 16'hFFFF, 32'h00000000, 16'hFFFF,
                         1'b1, 1'b0, 1'b1, 16'hFFFF};
        // address ack times out: error and straight to stop
        dir_rows[4]  = '{ROW_TXN,  MODE_WRITE, 8'h12, 16'hABCD, 32'h000000FF, 16'h0000,
                         1'b1, 1'b1, 1'b0, 16'h0000};
        // error flag holds over an idle tick
        dir_rows[5]  = '{ROW_TICK, MODE_TICK,  8'h00, 16'h0000, 32'h00000000, 16'h0000,
                         1'b0, 1'b0, 1'b0, 16'h0000};
        // address ack on the very last sample before the timeout, then a
        // pointer ack that times out, which a write does not check
        dir_rows[6]  = '{ROW_TXN,  MODE_WRITE, 8'hFF, 16'hFFFF, 32'h0000FFFA, 16'h0000,
                         1'b1, 1'b0, 1'b0, 16'h0000};
        // a read ignores ack timeouts
        dir_rows[7]  = '{ROW_TXN,  MODE_READ,  8'h00, 16'h0000, 32'h0000FF00, 16'h0000,
                         1'b1, 1'b0, 1'b1, 16'h0000};
        dir_rows[8]  = '{ROW_CFG,  MODE_TICK,  8'h00, 16'h0000, 32'h00000000, 16'h0000,
                         1'b0, 1'b0, 1'b0, 16'h0000};
        dir_rows[9]  = '{ROW_TXN,  MODE_WRITE, 8'hA5, 16'h8000, 32'h00030201, 16'h0000,
                         1'b1, 1'b0, 1'b0, 16'h0000};
        dir_rows[10] = '{ROW_CFG,  MODE_TICK,  8'h7F, 16'h0000, 32'h00000000, 16'h0000,
                         1'b0, 1'b0, 1'b0, 16'h0000};
        dir_rows[11] = '{ROW_TXN,  MODE_READ,  8'h5A, 16'h0000, 32'h01020304, 16'h7FFE,
                         1'b1, 1'b0, 1'b1, 16'h7FFE};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG:  set_address(row.ptr[6:0]);
                ROW_TICK: send_item(row.mode, row.ptr, row.word, 1'b1);
                default:  run_txn(row.mode, row.ptr, row.word, row.ack_dly, row.slave_word,
                                  '{row.chk_err, row.exp_err, row.chk_word, row.exp_word});
            endcase
        end

        // Random transactions; the sink holds off once at the start
        base_items = n_items;
        txn_no     = 0;
        hold_req   = 1'b1;
        while (n_items < base_items + RANDOM_ITEMS) begin
            in_burst = ($urandom_range(0, 3) == 0);
            if (txn_no % 5 == 4) begin
                r = $urandom_range(0, 9);
                if (r < 2) a = 7'd0;
                else if (r < 4) a = 7'h7F;
                else a = 7'($urandom);
                set_address(a);
            end
            txn_no++;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                repeat ($urandom_range(1, 6))
                    send_item(($urandom_range(0, 1) != 0) ? MODE_RSVD : MODE_TICK,
                              8'($urandom), 16'($urandom), ($urandom_range(0, 1) != 0));
            end else begin
                // mostly prompt acks, a few late ones and a few timeouts
                for (int k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 99)) inside
                        [0:69]:  ack_dly[k*8 +: 8] = 8'd0;
                        [70:93]: ack_dly[k*8 +: 8] = 8'($urandom_range(1, 4));
                        [94:96]: ack_dly[k*8 +: 8] = 8'($urandom_range(5, 250));
                        default: ack_dly[k*8 +: 8] = 8'hFF;
                    endcase
                end
                run_txn((r < 55) ? MODE_WRITE : MODE_READ, 8'($urandom), 16'($urandom),
                        ack_dly, 16'($urandom), '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (bus_levels_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_mism == 0 && bus_levels_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/i2crm_pkg.sv
sv/i2crm_core.sv
sv/i2c_register_master.sv
test/testbench.sv
